// ===== hdl/raster_roi_bounding_box_assert.svh =====
// Assertion macros used by the checker file.
// Both expect clk and rst in the scope where they are used.
`ifndef RASTER_ROI_BOUNDING_BOX_ASSERT_SVH
`define RASTER_ROI_BOUNDING_BOX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRBB_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRBB_HOLDS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rrbb_pkg.sv =====
package rrbb_pkg;

  localparam int CHAN_W      = 8;
  localparam int BOX_W       = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  // Classified pixel handed from the front queue to the back end
  typedef struct packed {
    logic valid;
    logic lit;
  } rrbb_item_t;

endpackage

// ===== hdl/rrbb_if.sv =====
interface rrbb_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [rrbb_pkg::CHAN_W-1:0] channel_zero;
  logic [rrbb_pkg::CHAN_W-1:0] channel_one;
  logic [rrbb_pkg::CHAN_W-1:0] channel_two;

  modport source (output valid, channel_zero, channel_one, channel_two, input ready);
  modport sink   (input valid, channel_zero, channel_one, channel_two, output ready);
endinterface

interface rrbb_box_if;
  logic                       valid;
  logic                       ready;
  logic [rrbb_pkg::BOX_W-1:0] box_left;
  logic [rrbb_pkg::BOX_W-1:0] box_top;
  logic [rrbb_pkg::BOX_W-1:0] box_width;
  logic [rrbb_pkg::BOX_W-1:0] box_height;

  modport source (output valid, box_left, box_top, box_width, box_height, input ready);
  modport sink   (input valid, box_left, box_top, box_width, box_height, output ready);
endinterface

// ===== hdl/raster_roi_bounding_box.sv =====
// Bounding box of the non-black region of a raster frame. Pixels enter one per clock in
// raster order while the queue has room; a pixel is lit when any channel is nonzero. The
// front end classifies each beat and parks it in a four-entry queue; the back end walks the
// column and row counters and updates the bounds at one beat per clock, but holds a frame's
// last pixel while a finished box still waits downstream. One box beat leaves on the last
// pixel of each frame through an output register; the queue only fills then. Frame width and
// height (index 0 and 1) are clamped to 1..MAX_DIMENSION and must be written while no pixel
// is in flight; a new size applies from the next pixel, mid-frame included.
module raster_roi_bounding_box #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rrbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrbb_pkg::CFG_W-1:0]     cfg_data,
  rrbb_pixel_if.sink                     pixel,
  rrbb_box_if.source                     box
);
  import rrbb_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int EW = (DW > CFG_W) ? DW : CFG_W;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) begin
      return DW'(1);
    end
    if (ve > EW'(MAX_DIMENSION)) begin
      return DW'(MAX_DIMENSION);
    end
    return DW'(ve);
  endfunction

  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;
  rrbb_item_t    item;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= eff_dim(RESET_FRAME_WIDTH);
      frame_height <= eff_dim(RESET_FRAME_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width  <= eff_dim(cfg_data);
        CFG_FRAME_HEIGHT: frame_height <= eff_dim(cfg_data);
        default: ;
      endcase
    end
  end

  rrbb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .item  (item),
    .pop   (pop)
  );

  rrbb_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .item         (item),
    .pop          (pop),
    .box          (box)
  );

endmodule

// ===== hdl/rrbb_front.sv =====
module rrbb_front (
  input  logic                clk,
  input  logic                rst,
  rrbb_pixel_if.sink          pixel,
  output rrbb_pkg::rrbb_item_t item,
  input  logic                pop
);
  import rrbb_pkg::*;

  logic              lit_queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              lit;

  assign lit         = |{pixel.channel_zero, pixel.channel_one, pixel.channel_two};
  assign pixel.ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign push        = pixel.valid && pixel.ready;

  assign item.valid = count != '0;
  assign item.lit   = lit_queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      lit_queue[wr_ptr] <= lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/rrbb_back.sv =====
module rrbb_back #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [$clog2(MAX_DIMENSION + 1)-1:0]   frame_width,
  input  logic [$clog2(MAX_DIMENSION + 1)-1:0]   frame_height,
  input  rrbb_pkg::rrbb_item_t                   item,
  output logic                                   pop,
  rrbb_box_if.source                             box
);
  import rrbb_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int DW = $clog2(MAX_DIMENSION + 1);

  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic          prev_lit;
  logic [DW-1:0] min_col;
  logic [DW-1:0] min_row;
  logic [CW-1:0] right_col;
  logic [DW-1:0] span;

  logic             out_valid;
  logic [BOX_W-1:0] left;
  logic [BOX_W-1:0] top;
  logic [BOX_W-1:0] bw;
  logic [BOX_W-1:0] bh;

  logic          first;
  logic [DW-1:0] col_d;
  logic [DW-1:0] row_d;
  logic [DW-1:0] mc_base;
  logic [DW-1:0] mr_base;
  logic [DW-1:0] min_col_next;
  logic [DW-1:0] min_row_next;
  logic          pair;
  logic [CW-1:0] right_col_next;
  logic [DW:0]   span_sum;
  logic [DW-1:0] span_next;
  logic          row_end;
  logic          last;
  logic          out_free;
  logic [DW-1:0] right_d;
  logic [DW-1:0] diff;
  logic [DW-1:0] left_val;
  logic [DW-1:0] top_val;
  logic [DW-1:0] bw_val;
  logic [DW-1:0] bh_val;

  always_comb begin
    first   = (col == '0) && (row == '0);
    col_d   = DW'(col);
    row_d   = DW'(row);
    // reload the minima with the current frame size on the first pixel
    mc_base = first ? frame_width : min_col;
    mr_base = first ? frame_height : min_row;

    min_col_next = (item.lit && (col_d < mc_base)) ? col_d : mc_base;
    min_row_next = (item.lit && (row_d < mr_base)) ? row_d : mr_base;

    pair           = item.lit && prev_lit;
    right_col_next = (pair && (col > right_col)) ? col : right_col;
    span_sum       = (DW + 1)'(span) + (DW + 1)'(min_row_next);
    span_next      = (pair && ((DW + 1)'(row_d) > span_sum)) ? row_d - min_row_next : span;

    row_end = ((DW + 1)'(col) + (DW + 1)'(1)) >= (DW + 1)'(frame_width);
    last    = row_end && (((DW + 1)'(row) + (DW + 1)'(1)) >= (DW + 1)'(frame_height));

    out_free = !out_valid || box.ready;
    pop      = item.valid && (!last || out_free);

    left_val = (min_col_next < frame_width) ? min_col_next : frame_width;
    top_val  = (min_row_next < frame_height) ? min_row_next : frame_height;
    right_d  = DW'(right_col_next);
    diff     = (right_d > min_col_next) ? right_d - min_col_next : DW'(1);
    bw_val   = (diff > frame_width) ? frame_width : diff;
    bh_val   = (span_next > frame_height) ? frame_height : span_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      prev_lit  <= 1'b0;
      right_col <= '0;
      span      <= DW'(1);
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (last) begin
          col       <= '0;
          row       <= '0;
          prev_lit  <= 1'b0;
          right_col <= '0;
          span      <= DW'(1);
        end else begin
          prev_lit  <= item.lit;
          right_col <= right_col_next;
          span      <= span_next;
          if (row_end) begin
            col <= '0;
            row <= row + CW'(1);
          end else begin
            col <= col + CW'(1);
          end
        end
      end
      if (pop && last) begin
        out_valid <= 1'b1;
      end else if (box.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      min_col <= min_col_next;
      min_row <= min_row_next;
    end
    if (pop && last) begin
      left <= BOX_W'(left_val);
      top  <= BOX_W'(top_val);
      bw   <= BOX_W'(bw_val);
      bh   <= BOX_W'(bh_val);
    end
  end

  assign box.valid      = out_valid;
  assign box.box_left   = left;
  assign box.box_top    = top;
  assign box.box_width  = bw;
  assign box.box_height = bh;

endmodule

// ===== hdl/rrbb_checker.sv =====
`include "raster_roi_bounding_box_assert.svh"

module rrbb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rrbb_pkg::BOX_W-1:0] box_left,
  input logic [rrbb_pkg::BOX_W-1:0] box_top,
  input logic [rrbb_pkg::BOX_W-1:0] box_width,
  input logic [rrbb_pkg::BOX_W-1:0] box_height
);

  logic [4*rrbb_pkg::BOX_W-1:0] box_beat;

  assign box_beat = {box_left, box_top, box_width, box_height};

  // a stalled box beat must stay put
  `RRBB_HOLDS_NEXT(a_box_hold, out_valid && !out_ready, out_valid && $stable(box_beat), "box beat changed while stalled")

  // width and height are clamped to at least one
  `RRBB_HOLDS(a_box_nonzero, out_valid, (box_width != '0) && (box_height != '0), "box side is zero")

  // the pixel queue only fills behind a box that waits downstream
  `RRBB_HOLDS(a_stall_cause, !in_ready, out_valid, "pixel input stalled with no box pending")

endmodule

bind raster_roi_bounding_box rrbb_checker u_rrbb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixel.ready),
  .out_valid  (box.valid),
  .out_ready  (box.ready),
  .box_left   (box.box_left),
  .box_top    (box.box_top),
  .box_width  (box.box_width),
  .box_height (box.box_height)
);
